@@ sv/pidl_pkg.sv @@
`default_nettype none

package pidl_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int VAL_W    = 64;

    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_DELETE = 2'd1;
    localparam logic [1:0] FN_READ   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic             ins;
        logic             del;
        logic [CMP_W-1:0] pos;
    } t_cmd;

endpackage

`default_nettype wire

@@ sv/pidl_cell.sv @@
`default_nettype none

module pidl_cell
    import pidl_pkg::*;
(
    input  wire              i_clk,
    input  wire  [IDX_W-1:0] i_idx,
    input  t_cmd             i_cmd,
    input  wire  [CMP_W-1:0] i_rd_pos,
    input  wire  [VAL_W-1:0] i_new_value,
    input  wire  [VAL_W-1:0] i_left_value,
    input  wire  [VAL_W-1:0] i_right_value,
    output logic [VAL_W-1:0] o_value,
    output logic [VAL_W-1:0] o_rd_value
);

    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] n_value;
    logic [CMP_W-1:0] idx_ext;

    assign idx_ext = CMP_W'(i_idx);

    always_comb begin
        n_value = r_value;
        if (i_cmd.ins) begin
            if (idx_ext > i_cmd.pos) begin
                n_value = i_left_value;
            end else if (idx_ext == i_cmd.pos) begin
                n_value = i_new_value;
            end
        end else if (i_cmd.del) begin
            if (idx_ext >= i_cmd.pos) begin
                n_value = i_right_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value    = r_value;
    assign o_rd_value = (idx_ext == i_rd_pos) ? r_value : '0;

endmodule

`default_nettype wire

@@ sv/positional_insert_delete_list.sv @@
// Positional insert/delete list.
// The input channel carries one word per operation: tuser holds the
// operation (insert, delete, read) and tdata holds the position and the
// value to insert. The output channel returns exactly one word per
// operation: tdata holds the value read and the entry count after the
// operation, and tuser holds the status.
// The entries live in a row of cells, one entry per cell. On an insert or
// a delete every cell loads from its left or right neighbor, loads the new
// value (the cell at the insert position), or holds, all in the same cycle.
// The result is registered: it appears in the cycle after the input word is
// taken, and a new word is taken every cycle while the receiver keeps up.
// When the receiver stalls, the result register holds its word and the
// input is held off until that word is taken.
// Reset clears the entry count and the output valid; the cell contents
// are not cleared, since only cells below the count are ever read.
`default_nettype none

module positional_insert_delete_list
    import pidl_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [6:0] position, [70:7] new_value, [71] zero
    input  wire  [71:0] i_s_axis_tdata,
    // [1:0] func
    input  wire  [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // [63:0] read_value, [70:64] entry_count, [71] zero
    output logic [71:0] o_m_axis_tdata,
    // [1:0] status
    output logic [1:0]  o_m_axis_tuser
);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_value;
    logic [POS_W-1:0] r_out_count;
    logic [1:0]       r_out_status;

    logic             accept;
    logic [1:0]       func;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [VAL_W-1:0] new_value;
    logic             full;
    logic             in_range;
    t_cmd             cmd;
    logic [VAL_W-1:0] rd_value;
    logic [1:0]       status;

    logic [VAL_W-1:0] cell_value [CAPACITY];
    logic [VAL_W-1:0] cell_rd    [CAPACITY];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign func            = i_s_axis_tuser;
    assign pos_ext         = CMP_W'(i_s_axis_tdata[POS_W-1:0]);
    assign new_value       = i_s_axis_tdata[POS_W +: VAL_W];
    assign cnt_ext         = CMP_W'(r_cnt);
    assign full            = (r_cnt == CNT_W'(CAPACITY));
    assign in_range        = (pos_ext < cnt_ext);

    always_comb begin
        cmd.ins = accept && (func == FN_INSERT) && !full;
        cmd.del = accept && (func == FN_DELETE) && in_range;
        cmd.pos = (cmd.ins && (pos_ext > cnt_ext)) ? cnt_ext : pos_ext;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [VAL_W-1:0] left_value;
            logic [VAL_W-1:0] right_value;
            if (g == 0) begin : g_first
                assign left_value = '0;
            end else begin : g_mid_l
                assign left_value = cell_value[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign right_value = '0;
            end else begin : g_mid_r
                assign right_value = cell_value[g+1];
            end
            pidl_cell u_cell (
                .i_clk         (i_clk),
                .i_idx         (IDX_W'(g)),
                .i_cmd         (cmd),
                .i_rd_pos      (pos_ext),
                .i_new_value   (new_value),
                .i_left_value  (left_value),
                .i_right_value (right_value),
                .o_value       (cell_value[g]),
                .o_rd_value    (cell_rd[g])
            );
        end
    endgenerate

    always_comb begin
        rd_value = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_value = rd_value | cell_rd[k];
        end
    end

    always_comb begin
        n_cnt  = r_cnt;
        status = ST_OK;
        unique case (func)
            FN_INSERT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            FN_DELETE: begin
                if (!in_range) begin
                    status = ST_RANGE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            FN_READ: begin
                if (!in_range) begin
                    status = ST_RANGE;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_cnt       <= n_cnt;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_value  <= (func == FN_READ && in_range) ? rd_value : '0;
            r_out_count  <= POS_W'(n_cnt);
            r_out_status <= status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_count, r_out_value};
    assign o_m_axis_tuser  = r_out_status;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
module tb;
    import pidl_pkg::*;

    localparam logic [1:0] FN_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 500000;
    localparam int         LONG_HOLD   = 120;
    localparam int         DRAIN_WAIT  = 20;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic [6:0]       entry_count;
        logic [1:0]       status;
    } t_list_reply;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic [71:0] s_data  = '0;
    logic [1:0]  s_user  = '0;
    logic        m_ready = 1'b0;
    wire         s_ready;
    wire         m_valid;
    wire  [71:0] m_data;
    wire  [1:0]  m_user;

    logic [VAL_W-1:0] list_vals [CAPACITY];
    int               list_len     = 0;
    t_list_reply      due_replies[$];
    int               fail_count   = 0;
    int               cycle_count  = 0;
    bit               gaps_on      = 1'b1;
    bit               stalls_on    = 1'b1;
    int               hold_reqs    = 0;

    positional_insert_delete_list i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        // [6:0] position, [70:7] new_value, [71] zero
        .i_s_axis_tdata  (s_data),
        // [1:0] func
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        // [63:0] read_value, [70:64] entry_count, [71] zero
        .o_m_axis_tdata  (m_data),
        // [1:0] status
        .o_m_axis_tuser  (m_user)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_list_reply model_list_op(input logic [1:0] fn,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [VAL_W-1:0] val);
        t_list_reply r;
        int p;
        r = '0;
        r.status = ST_OK;
        p = pos;
        case (fn)
            FN_INSERT: begin
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    if (p > list_len) p = list_len;
                    for (int k = list_len; k > p; k--) list_vals[k] = list_vals[k-1];
                    list_vals[p] = val;
                    list_len++;
                end
            end
            FN_DELETE: begin
                if (p >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    for (int k = p; k + 1 < list_len; k++) list_vals[k] = list_vals[k+1];
                    list_len--;
                end
            end
            FN_READ: begin
                if (p >= list_len) r.status = ST_RANGE;
                else r.read_value = list_vals[p];
            end
            default: ;
        endcase
        r.entry_count = 7'(list_len);
        return r;
    endfunction

    function automatic logic [POS_W-1:0] pick_pos(input bit for_insert);
        if ($urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, 127));
        if (for_insert) return POS_W'($urandom_range(0, list_len));
        if (list_len == 0) return '0;
        return POS_W'($urandom_range(0, list_len - 1));
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return '1;
            3: return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_op(input logic [1:0] fn, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val);
        int gap;
        gap = gaps_on ? idle_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= fn;
        s_data  <= {1'b0, val, pos};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        due_replies.push_back(model_list_op(fn, pos, val));
    endtask

    task automatic send_random_op(input int ins_pct, input int del_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_pct) send_op(FN_INSERT, pick_pos(1'b1), pick_value());
        else if (r < ins_pct + del_pct) send_op(FN_DELETE, pick_pos(1'b0), pick_value());
        else if (r < 98) send_op(FN_READ, pick_pos(1'b0), pick_value());
        else send_op(FN_UNUSED, pick_pos(1'b0), pick_value());
    endtask

    // Receiver: random stalls, plus a long hold-off whenever a test asks for one.
    initial begin
        int stall;
        int hold_seen;
        hold_seen = 0;
        forever begin
            @(posedge clk);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (stalls_on && $urandom_range(0, 99) < 25) begin
                m_ready <= 1'b0;
                stall = idle_len() + 1;
                repeat (stall) @(posedge clk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        t_list_reply want;
        t_list_reply got;
        if (rst_n && m_valid && m_ready) begin
            got.read_value  = m_data[63:0];
            got.entry_count = m_data[70:64];
            got.status      = m_user;
            if (due_replies.size() == 0) begin
                $error("unexpected word: read_value %h entry_count %0d status %0d",
                       got.read_value, got.entry_count, got.status);
                fail_count++;
            end else begin
                want = due_replies.pop_front();
                if (got.read_value !== want.read_value) begin
                    $error("read_value: expected %h, got %h", want.read_value, got.read_value);
                    fail_count++;
                end
                if (got.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, got.entry_count);
                    fail_count++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_edge_cases();
        send_op(FN_READ, 7'd0, '0);
        send_op(FN_DELETE, 7'd0, '0);
        send_op(FN_UNUSED, 7'd127, '1);
        send_op(FN_INSERT, 7'd127, 64'h7FFF_FFFF_FFFF_FFFF);
        send_op(FN_INSERT, 7'd0, 64'h8000_0000_0000_0000);
        send_op(FN_INSERT, 7'd1, '0);
        send_op(FN_INSERT, 7'd100, '1);
        send_op(FN_INSERT, 7'd2, 64'h5555_5555_5555_5555);
        send_op(FN_INSERT, 7'd5, 64'hAAAA_AAAA_AAAA_AAAA);
        for (int i = 0; i < 6; i++) send_op(FN_READ, POS_W'(i), '0);
        send_op(FN_READ, 7'd6, '0);
        send_op(FN_READ, 7'd127, '1);
        send_op(FN_DELETE, 7'd127, '0);
        send_op(FN_DELETE, 7'd6, '0);
        send_op(FN_DELETE, 7'd2, '0);
        send_op(FN_DELETE, 7'd0, '0);
        send_op(FN_DELETE, 7'd3, '0);
        send_op(FN_UNUSED, 7'd0, '0);
        send_op(FN_READ, 7'd0, '0);
        send_op(FN_READ, 7'd2, '0);
    endtask

    task automatic test_fill_to_full();
        while (list_len < CAPACITY) send_op(FN_INSERT, pick_pos(1'b1), pick_value());
        send_op(FN_INSERT, 7'd0, pick_value());
        send_op(FN_INSERT, 7'd127, pick_value());
        send_op(FN_INSERT, POS_W'(CAPACITY), pick_value());
        send_op(FN_READ, POS_W'(CAPACITY - 1), '0);
        send_op(FN_READ, POS_W'(CAPACITY), '0);
        send_op(FN_READ, 7'd0, '0);
    endtask

    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        hold_reqs++;
        for (int i = 0; i < 24; i++) send_random_op(30, 30);
        gaps_on = 1'b1;
    endtask

    task automatic test_drain_to_empty();
        while (list_len > 0) begin
            case ($urandom_range(0, 2))
                0: send_op(FN_DELETE, 7'd0, pick_value());
                1: send_op(FN_DELETE, POS_W'(list_len - 1), pick_value());
                default: send_op(FN_DELETE, pick_pos(1'b0), pick_value());
            endcase
        end
        send_op(FN_DELETE, 7'd0, '0);
        send_op(FN_READ, 7'd0, '0);
    endtask

    task automatic test_random_mix();
        for (int seg = 0; seg < 8; seg++) begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < 130; i++) begin
                case (seg % 3)
                    0: send_random_op(60, 20);
                    1: send_random_op(20, 60);
                    default: send_random_op(35, 35);
                endcase
            end
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edge_cases();
        test_fill_to_full();
        test_output_backpressure();
        test_drain_to_empty();
        test_random_mix();
        test_fill_to_full();
        test_drain_to_empty();
        s_valid <= 1'b0;
        while (due_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
